// ----- src/bfd_pkg.sv -----
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared types and codes for the bootloader reply frame deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bfd_pkg;

  // position within a frame
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TYPE = 2'd1,
    PH_RESP = 2'd2,
    PH_BODY = 2'd3
  } phase_t;

  // frame status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd1;
  localparam logic [2:0] ST_WRITE_FAIL  = 3'd2;
  localparam logic [2:0] ST_READ_FAIL   = 3'd3;
  localparam logic [2:0] ST_OTHER_ERR   = 3'd4;
  localparam logic [2:0] ST_WRONG_TYPE  = 3'd5;
  localparam logic [2:0] ST_CHECKSUM    = 3'd6;
  localparam logic [2:0] ST_BAD_LENGTH  = 3'd7;

  // response codes carried in the frame
  localparam logic [7:0] RSP_OK          = 8'h00;
  localparam logic [7:0] RSP_UNSUPPORTED = 8'hff;
  localparam logic [7:0] RSP_WRITE_FAIL  = 8'hfe;
  localparam logic [7:0] RSP_READ_FAIL   = 8'hf9;

  // length byte covers type, response and checksum
  localparam logic [7:0] HDR_BYTES = 8'd3;

  function automatic logic [2:0] classify(input logic [7:0] check,
                                          input logic [7:0] rsp,
                                          input logic [7:0] typ,
                                          input logic [7:0] exp_type);
    logic [2:0] st;
    begin
      if (check != 8'h00) begin
        st = ST_CHECKSUM;
      end else begin
        unique case (rsp)
          RSP_OK:          st = (typ != exp_type) ? ST_WRONG_TYPE : ST_OK;
          RSP_UNSUPPORTED: st = ST_UNSUPPORTED;
          RSP_WRITE_FAIL:  st = ST_WRITE_FAIL;
          RSP_READ_FAIL:   st = ST_READ_FAIL;
          default:         st = ST_OTHER_ERR;
        endcase
      end
      return st;
    end
  endfunction

endpackage

`default_nettype wire

// ----- src/bootloader_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// bootloader_frame_deframer
// Checks length-prefixed reply frames with an XOR checksum, one byte a beat,
// passes payload bytes through, reports status on a last or bad length byte.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  in        in_valid / in_stall       rx_byte
//  out       out_valid / out_stall     data_valid data_byte frame_end status
//                                      msg_type response_code payload_length
//  cfg       cfg_write_en              cfg_write_data (expected_type)
//
//  one beat per cycle sustained while out_stall is low; a byte's result is
//  registered in the result register as the byte leaves the input register.
//  the frame state advances as a byte moves from the input register to the
//  result register; stall on the output holds both registers.
//  rst is synchronous and clears the handshake and frame state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bootloader_frame_deframer
  import bfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write_en,
  input  wire logic [7:0] cfg_write_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            data_valid,
  output logic [7:0]      data_byte,
  output logic            frame_end,
  output logic [2:0]      status,
  output logic [7:0]      msg_type,
  output logic [7:0]      response_code,
  output logic [7:0]      payload_length
);

  logic       in_reg_valid;
  logic [7:0] in_reg_byte;
  logic [7:0] expected_type;

  phase_t     phase,         phase_next;
  logic [7:0] bytes_left,    bytes_left_next;
  logic [7:0] running_xor,   running_xor_next;
  logic [7:0] held_type,     held_type_next;
  logic [7:0] held_response, held_response_next;
  logic [7:0] held_length,   held_length_next;

  logic       res_data_valid;
  logic [7:0] res_data_byte;
  logic       res_frame_end;
  logic [2:0] res_status;
  logic [7:0] res_msg_type;
  logic [7:0] res_response_code;
  logic [7:0] res_payload_length;

  logic       advance;
  logic [7:0] xor_with_byte;
  logic       last_byte;

  assign advance  = in_reg_valid && (!out_valid || !out_stall);
  assign in_stall = in_reg_valid && !advance;

  assign xor_with_byte = running_xor ^ in_reg_byte;
  assign last_byte     = (bytes_left <= 8'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_type <= 8'h00;
    end else if (cfg_write_en) begin
      expected_type <= cfg_write_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg_byte <= rx_byte;
    end
  end

  // next frame state
  always_comb begin
    phase_next         = phase;
    bytes_left_next    = bytes_left;
    running_xor_next   = running_xor;
    held_type_next     = held_type;
    held_response_next = held_response;
    held_length_next   = held_length;
    unique case (phase)
      PH_IDLE: begin
        if (in_reg_byte >= HDR_BYTES) begin
          held_length_next = in_reg_byte;
          running_xor_next = in_reg_byte;
          bytes_left_next  = in_reg_byte;
          phase_next       = PH_TYPE;
        end
      end
      PH_TYPE: begin
        held_type_next   = in_reg_byte;
        running_xor_next = xor_with_byte;
        bytes_left_next  = bytes_left - 8'd1;
        phase_next       = PH_RESP;
      end
      PH_RESP: begin
        held_response_next = in_reg_byte;
        running_xor_next   = xor_with_byte;
        bytes_left_next    = bytes_left - 8'd1;
        phase_next         = PH_BODY;
      end
      PH_BODY: begin
        running_xor_next = xor_with_byte;
        if (last_byte) begin
          bytes_left_next = 8'd0;
          phase_next      = PH_IDLE;
        end else begin
          bytes_left_next = bytes_left - 8'd1;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  // result of the byte in the input register
  always_comb begin
    res_data_valid     = 1'b0;
    res_data_byte      = 8'h00;
    res_frame_end      = 1'b0;
    res_status         = ST_OK;
    res_msg_type       = 8'h00;
    res_response_code  = 8'h00;
    res_payload_length = 8'h00;
    unique case (phase)
      PH_IDLE: begin
        if (in_reg_byte < HDR_BYTES) begin
          res_frame_end = 1'b1;
          res_status    = ST_BAD_LENGTH;
        end
      end
      PH_TYPE, PH_RESP: begin
      end
      PH_BODY: begin
        if (last_byte) begin
          res_frame_end      = 1'b1;
          res_status         = classify(xor_with_byte, held_response, held_type,
                                        expected_type);
          res_msg_type       = held_type;
          res_response_code  = held_response;
          res_payload_length = held_length - HDR_BYTES;
        end else begin
          res_data_valid = 1'b1;
          res_data_byte  = in_reg_byte;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bytes_left    <= 8'd0;
      running_xor   <= 8'd0;
      held_type     <= 8'd0;
      held_response <= 8'd0;
      held_length   <= 8'd0;
    end else if (advance) begin
      phase         <= phase_next;
      bytes_left    <= bytes_left_next;
      running_xor   <= running_xor_next;
      held_type     <= held_type_next;
      held_response <= held_response_next;
      held_length   <= held_length_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data_valid     <= res_data_valid;
      data_byte      <= res_data_byte;
      frame_end      <= res_frame_end;
      status         <= res_status;
      msg_type       <= res_msg_type;
      response_code  <= res_response_code;
      payload_length <= res_payload_length;
    end
  end

endmodule

`default_nettype wire

// ----- test/bootloader_frame_deframer_tb.sv -----
// ----------------------------------------------------------------------------
// bootloader_frame_deframer_tb
// Sends reply frames byte by byte into the deframer and checks every output
// beat against a bit-accurate prediction of the frame state machine. Covers
// bad length bytes, every response code, wrong type, checksum errors,
// minimal and maximal frames, under random idling on both sides and a long
// output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bootloader_frame_deframer_tb
  import bfd_pkg::*;
;

  typedef struct packed {
    logic       dv;
    logic [7:0] db;
    logic       fe;
    logic [2:0] st;
    logic [7:0] mt;
    logic [7:0] rc;
    logic [7:0] pl;
  } reply_beat_t;

  // tracks frame position and checksum, queues the beat each byte must give
  class deframe_predictor;
    phase_t      pos;
    logic [7:0]  left;
    logic [7:0]  xor_acc;
    logic [7:0]  typ_q;
    logic [7:0]  rsp_q;
    logic [7:0]  len_q;
    logic [7:0]  want_type;
    reply_beat_t due_beats[$];
    int          errors;

    function new();
      pos = PH_IDLE;
      left = 8'd0;
      xor_acc = 8'd0;
      typ_q = 8'd0;
      rsp_q = 8'd0;
      len_q = 8'd0;
      want_type = 8'd0;
      errors = 0;
    endfunction

    function void set_type(logic [7:0] t);
      want_type = t;
    endfunction

    function int pending();
      return due_beats.size();
    endfunction

    function logic [2:0] frame_status();
      if (xor_acc != 8'h00) return ST_CHECKSUM;
      case (rsp_q)
        RSP_OK:          return (typ_q == want_type) ? ST_OK : ST_WRONG_TYPE;
        RSP_UNSUPPORTED: return ST_UNSUPPORTED;
        RSP_WRITE_FAIL:  return ST_WRITE_FAIL;
        RSP_READ_FAIL:   return ST_READ_FAIL;
        default:         return ST_OTHER_ERR;
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      reply_beat_t r;
      r = '0;
      case (pos)
        PH_IDLE: begin
          if (b < HDR_BYTES) begin
            r.fe = 1'b1;
            r.st = ST_BAD_LENGTH;
          end else begin
            len_q = b;
            xor_acc = b;
            left = b;
            pos = PH_TYPE;
          end
        end
        PH_TYPE: begin
          typ_q = b;
          xor_acc ^= b;
          left = left - 8'd1;
          pos = PH_RESP;
        end
        PH_RESP: begin
          rsp_q = b;
          xor_acc ^= b;
          left = left - 8'd1;
          pos = PH_BODY;
        end
        default: begin
          xor_acc ^= b;
          if (left <= 8'd1) begin
            r.fe = 1'b1;
            r.st = frame_status();
            r.mt = typ_q;
            r.rc = rsp_q;
            r.pl = len_q - HDR_BYTES;
            left = 8'd0;
            pos = PH_IDLE;
          end else begin
            r.dv = 1'b1;
            r.db = b;
            left = left - 8'd1;
          end
        end
      endcase
      due_beats.push_back(r);
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(reply_beat_t got);
      reply_beat_t want;
      if (due_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got %h", $time, got);
        errors++;
        return;
      end
      want = due_beats.pop_front();
      compare("data_valid", want.dv, got.dv);
      compare("data_byte", want.db, got.db);
      compare("frame_end", want.fe, got.fe);
      compare("status", want.st, got.st);
      compare("msg_type", want.mt, got.mt);
      compare("response_code", want.rc, got.rc);
      compare("payload_length", want.pl, got.pl);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write_en = 1'b0;
  logic [7:0] cfg_write_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       data_valid;
  logic [7:0] data_byte;
  logic       frame_end;
  logic [2:0] status;
  logic [7:0] msg_type;
  logic [7:0] response_code;
  logic [7:0] payload_length;

  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  logic       hold_off = 1'b0;
  int         bytes_sent = 0;
  logic [7:0] cur_type = 8'd0;

  deframe_predictor frame_model = new();

  bootloader_frame_deframer uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .data_valid     (data_valid),
    .data_byte      (data_byte),
    .frame_end      (frame_end),
    .status         (status),
    .msg_type       (msg_type),
    .response_code  (response_code),
    .payload_length (payload_length)
  );

  always #10 clk = ~clk;

  // output side: check accepted beats, then pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      frame_model.check_result(reply_beat_t'{data_valid, data_byte, frame_end, status,
                                             msg_type, response_code, payload_length});
    end
    out_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frame_model.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] len, input logic [7:0] typ,
                            input logic [7:0] rsp, input logic corrupt);
    int         i;
    logic [7:0] chk;
    logic [7:0] b;
    chk = len ^ typ ^ rsp;
    send_byte(len);
    send_byte(typ);
    send_byte(rsp);
    for (i = 0; i < int'(len) - 3; i++) begin
      b = 8'($urandom_range(0, 255));
      chk ^= b;
      send_byte(b);
    end
    if (corrupt) chk ^= 8'($urandom_range(1, 255));
    send_byte(chk);
  endtask

  task automatic random_frame();
    int         pick;
    logic [7:0] len;
    logic [7:0] typ;
    logic [7:0] rsp;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      // stray byte too short to be a length
      send_byte(8'($urandom_range(0, 2)));
      return;
    end
    len = (pick < 90) ? 8'($urandom_range(3, 10)) : 8'($urandom_range(11, 40));
    typ = ($urandom_range(0, 99) < 60) ? cur_type : 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3, 4: rsp = RSP_OK;
      5:             rsp = RSP_UNSUPPORTED;
      6:             rsp = RSP_WRITE_FAIL;
      7:             rsp = RSP_READ_FAIL;
      default:       rsp = 8'($urandom_range(0, 255));
    endcase
    send_frame(len, typ, rsp, $urandom_range(0, 99) < 12);
  endtask

  task automatic random_traffic(input int budget);
    int stop_at;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) random_frame();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (frame_model.pending() != 0) @(posedge clk);
  endtask

  task automatic write_type(input logic [7:0] t);
    cfg_write_en <= 1'b1;
    cfg_write_data <= t;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    frame_model.set_type(t);
    cur_type = t;
  endtask

  initial begin
    #2000000;
    $display("bootloader_frame_deframer_tb: FAIL");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender mostly busy, receiver mostly stalled
    send_idle_pct <= 20;
    recv_idle_pct <= 82;
    write_type(8'hff);
    send_byte(8'h00);
    send_byte(8'h02);
    send_frame(8'd3, 8'hff, RSP_OK, 1'b0);
    send_frame(8'd3, 8'h00, RSP_OK, 1'b0);
    send_frame(8'd3, 8'h41, RSP_UNSUPPORTED, 1'b0);
    send_frame(8'd4, 8'hff, RSP_WRITE_FAIL, 1'b0);
    send_frame(8'd3, 8'h10, RSP_READ_FAIL, 1'b0);
    // checksum error wins over an otherwise unknown response
    send_frame(8'd3, 8'hff, 8'h80, 1'b1);
    random_traffic(45);
    drain();

    send_idle_pct <= 82;
    recv_idle_pct <= 20;
    write_type(8'h00);
    random_traffic(45);
    drain();

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    write_type(8'($urandom_range(1, 254)));
    fork
      begin
        hold_off <= 1'b1;
        repeat (150) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    send_frame(8'd255, cur_type, RSP_OK, 1'b0);
    random_traffic(35);
    drain();

    repeat (4) @(posedge clk);
    if (frame_model.errors == 0 && frame_model.pending() == 0) begin
      $display("bootloader_frame_deframer_tb: PASS");
    end else begin
      $display("bootloader_frame_deframer_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/bfd_pkg.sv
src/bootloader_frame_deframer.sv
test/bootloader_frame_deframer_tb.sv
